@@ src/absg_pkg.sv @@
`timescale 1ns / 1ps

package absg_pkg;

   localparam int unsigned SizeW     = 19;
   localparam int unsigned TargetW   = 24;
   localparam int unsigned WordW     = 32;
   localparam int unsigned NumW      = SizeW + TargetW;
   localparam int unsigned DividendW = NumW + 2;
   localparam int unsigned DivisorW  = WordW + 1;
   localparam int unsigned CountW    = $clog2(DividendW);
   localparam int unsigned AddrW     = 4;

   localparam logic [SizeW-1:0]   SizeCeiling   = 19'd262144;
   localparam logic [WordW-1:0]   MinElapsedUs  = 32'd10;
   localparam logic [TargetW-1:0] TargetReset   = 24'd250000;
   localparam logic [SizeW-1:0]   InitialReset  = 19'd64;
   localparam logic [SizeW-1:0]   MaxReset      = 19'd262144;
   localparam logic [CountW-1:0]  DivLastCount  = CountW'(DividendW - 1);

   localparam logic [1:0] RegTarget  = 2'd0;
   localparam logic [1:0] RegInitial = 2'd1;
   localparam logic [1:0] RegMax     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_CLAMP,
      ST_DONE
   } absg_state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_start;
      logic div_step;
      logic clamp;
      logic commit;
   } absg_cmd_type;

   typedef struct packed {
      logic recompute;
      logic div_last;
      logic out_free;
   } absg_sts_type;

   typedef struct packed {
      logic [TargetW-1:0] target_batch_us;
      logic [SizeW-1:0]   initial_batch;
      logic [SizeW-1:0]   max_batch;
   } absg_cfg_type;

endpackage

@@ src/absg_req_if.sv @@
`timescale 1ns / 1ps

interface absg_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic        scene_active;
   logic signed [absg_pkg::WordW-1:0] completed_tick;
   logic [absg_pkg::WordW-1:0]        elapsed_us;

   modport source (output valid, func, scene_active, completed_tick, elapsed_us,
                   input ready);
   modport sink (input valid, func, scene_active, completed_tick, elapsed_us,
                 output ready);
endinterface

@@ src/absg_rsp_if.sv @@
`timescale 1ns / 1ps

interface absg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [absg_pkg::SizeW-1:0]  batch_to_run;
   logic                        restore_stock;
   logic [absg_pkg::SizeW-1:0]  steps_done;
   logic                        batch_updated;
   logic [absg_pkg::SizeW-1:0]  next_batch;

   modport source (output valid, batch_to_run, restore_stock, steps_done, batch_updated,
                   next_batch, input ready);
   modport sink (input valid, batch_to_run, restore_stock, steps_done, batch_updated,
                 next_batch, output ready);
endinterface

@@ src/adaptive_batch_size_governor.sv @@
`timescale 1ns / 1ps

// adaptive batch size governor
// req_chan carries one event word: func 0 prepares a batch (scene_active 1 arms
// it, 0 leaves active mode), func 1 reports a finished batch with its last
// completed tick and elapsed microseconds.
// rsp_chan returns exactly one result word for every event word, in order.
// csr_* is an APB-style port: target_batch_us at 0x0, initial_batch at 0x4,
// max_batch at 0x8; pready is always high, reads return the register.
// a prepare, or a finish that does not rescale, is loaded into the output
// register after the multiply state; a finish that rescales also passes a
// 45-bit bit-serial divide of 45 steps and the clamp stage; the next word is
// taken in the cycle after the result is loaded.
// one event word is in flight at a time; a new one is taken once the previous
// result sits in the output register, even if the receiver has not taken it.
// if the receiver stalls, the result holds in the output register and the
// next word waits in the datapath until the register frees.
// reset returns the registers to their defaults, the batch size to 64 and
// clears the armed sample and active mode; no word is taken during reset.

module adaptive_batch_size_governor (
   input  logic                        clock,
   input  logic                        reset,
   absg_req_if.sink                    req_chan,
   absg_rsp_if.source                  rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [absg_pkg::AddrW-1:0]  csr_paddr,
   input  logic [absg_pkg::WordW-1:0]  csr_pwdata,
   output logic [absg_pkg::WordW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   absg_pkg::absg_cfg_type cfg;
   absg_pkg::absg_cmd_type cmd;
   absg_pkg::absg_sts_type sts;

   absg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   absg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   absg_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .sts               (sts),
      .in_func           (req_chan.func),
      .in_scene_active   (req_chan.scene_active),
      .in_completed_tick (req_chan.completed_tick),
      .in_elapsed_us     (req_chan.elapsed_us),
      .out_ready         (rsp_chan.ready),
      .out_valid         (rsp_chan.valid),
      .out_batch_to_run  (rsp_chan.batch_to_run),
      .out_restore_stock (rsp_chan.restore_stock),
      .out_steps_done    (rsp_chan.steps_done),
      .out_batch_updated (rsp_chan.batch_updated),
      .out_next_batch    (rsp_chan.next_batch)
   );

endmodule

@@ src/absg_csr.sv @@
`timescale 1ns / 1ps

module absg_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [absg_pkg::AddrW-1:0]  csr_paddr,
   input  logic [absg_pkg::WordW-1:0]  csr_pwdata,
   output logic [absg_pkg::WordW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output absg_pkg::absg_cfg_type      cfg
);

   logic [absg_pkg::TargetW-1:0] target_ff;
   logic [absg_pkg::SizeW-1:0]   initial_ff;
   logic [absg_pkg::SizeW-1:0]   max_ff;
   logic                         wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= absg_pkg::TargetReset;
         initial_ff <= absg_pkg::InitialReset;
         max_ff     <= absg_pkg::MaxReset;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            absg_pkg::RegTarget:  target_ff  <= csr_pwdata[absg_pkg::TargetW-1:0];
            absg_pkg::RegInitial: initial_ff <= csr_pwdata[absg_pkg::SizeW-1:0];
            absg_pkg::RegMax:     max_ff     <= csr_pwdata[absg_pkg::SizeW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         absg_pkg::RegTarget:  csr_prdata = {8'd0, target_ff};
         absg_pkg::RegInitial: csr_prdata = {13'd0, initial_ff};
         absg_pkg::RegMax:     csr_prdata = {13'd0, max_ff};
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg.target_batch_us = target_ff;
   assign cfg.initial_batch   = initial_ff;
   assign cfg.max_batch       = max_ff;

endmodule

@@ src/absg_ctrl.sv @@
`timescale 1ns / 1ps

module absg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  absg_pkg::absg_sts_type  sts,
   output absg_pkg::absg_cmd_type  cmd
);

   absg_pkg::absg_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= absg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         absg_pkg::ST_IDLE: begin
            if (req_valid) state_in = absg_pkg::ST_MUL;
         end
         absg_pkg::ST_MUL: begin
            state_in = sts.recompute ? absg_pkg::ST_DIV_LOAD : absg_pkg::ST_DONE;
         end
         absg_pkg::ST_DIV_LOAD: state_in = absg_pkg::ST_DIV;
         absg_pkg::ST_DIV: begin
            if (sts.div_last) state_in = absg_pkg::ST_CLAMP;
         end
         absg_pkg::ST_CLAMP: state_in = absg_pkg::ST_DONE;
         absg_pkg::ST_DONE: begin
            if (sts.out_free) state_in = absg_pkg::ST_IDLE;
         end
         default: state_in = absg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         absg_pkg::ST_IDLE: begin
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         absg_pkg::ST_MUL:      cmd.mul       = 1'b1;
         absg_pkg::ST_DIV_LOAD: cmd.div_start = 1'b1;
         absg_pkg::ST_DIV:      cmd.div_step  = 1'b1;
         absg_pkg::ST_CLAMP:    cmd.clamp     = 1'b1;
         absg_pkg::ST_DONE:     cmd.commit    = sts.out_free;
         default: ;
      endcase
   end

endmodule

@@ src/absg_dp.sv @@
`timescale 1ns / 1ps

module absg_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  absg_pkg::absg_cfg_type             cfg,
   input  absg_pkg::absg_cmd_type             cmd,
   output absg_pkg::absg_sts_type             sts,
   input  logic                               in_func,
   input  logic                               in_scene_active,
   input  logic signed [absg_pkg::WordW-1:0]  in_completed_tick,
   input  logic [absg_pkg::WordW-1:0]         in_elapsed_us,
   input  logic                               out_ready,
   output logic                               out_valid,
   output logic [absg_pkg::SizeW-1:0]         out_batch_to_run,
   output logic                               out_restore_stock,
   output logic [absg_pkg::SizeW-1:0]         out_steps_done,
   output logic                               out_batch_updated,
   output logic [absg_pkg::SizeW-1:0]         out_next_batch
);

   localparam int unsigned SizeW = absg_pkg::SizeW;
   localparam int unsigned WordW = absg_pkg::WordW;
   localparam int unsigned DvdW  = absg_pkg::DividendW;
   localparam int unsigned DvsW  = absg_pkg::DivisorW;
   localparam int unsigned NumW  = absg_pkg::NumW;
   localparam int unsigned CntW  = absg_pkg::CountW;

   // latched word
   logic                    func_ff, scene_ff;
   logic signed [WordW-1:0] tick_ff;
   logic [WordW-1:0]        elapsed_ff;

   // governor state
   logic [SizeW-1:0] batch_ff, batch_in;
   logic [SizeW-1:0] prepared_ff, prepared_in;
   logic             armed_ff, armed_in;
   logic             active_ff, active_in;

   // arithmetic
   logic [absg_pkg::NumW-1:0]   num_ff;
   logic [DvdW-1:0]             quo_ff;
   logic [DvsW-1:0]             rem_ff;
   logic [absg_pkg::CountW-1:0] cnt_ff;
   logic [SizeW-1:0]            new_size_ff;

   // result register
   logic             rsp_valid_ff;
   logic [SizeW-1:0] run_ff, steps_ff, next_ff;
   logic             restore_ff, updated_ff;

   logic [SizeW-1:0] eff_max, eff_init;
   logic [WordW-1:0] e_clamped;
   logic [DvsW-1:0]  divisor;
   logic [DvsW:0]    rem_sh;
   logic             rem_ge;
   logic [WordW:0]   tick_p1;
   logic [SizeW-1:0] steps;
   logic             out_free;
   logic [DvdW-1:0]  cand;
   logic [16:0]      lo;
   logic [20:0]      hi;
   logic [SizeW-1:0] cand_sz, diff;
   logic [22:0]      diff_x20;
   logic [SizeW-1:0] clamp_size;
   logic [SizeW-1:0] run_in, steps_in;
   logic             restore_in, updated_in;

   always_comb begin
      eff_max = cfg.max_batch;
      if (eff_max == '0) eff_max = SizeW'(1);
      if (eff_max > absg_pkg::SizeCeiling) eff_max = absg_pkg::SizeCeiling;
      eff_init = cfg.initial_batch;
      if (eff_init == '0) eff_init = SizeW'(1);
      if (eff_init > eff_max) eff_init = eff_max;
   end

   assign e_clamped = (elapsed_ff < absg_pkg::MinElapsedUs) ? absg_pkg::MinElapsedUs
                                                            : elapsed_ff;
   assign divisor   = {e_clamped, 1'b0};

   always_comb begin
      tick_p1 = (WordW+1)'(1) + {tick_ff[WordW-1], tick_ff};
      if (tick_p1[WordW]) begin
         steps = '0;
      end else if (tick_p1[WordW-1:0] > {13'd0, prepared_ff}) begin
         steps = prepared_ff;
      end else begin
         steps = tick_p1[SizeW-1:0];
      end
   end

   assign sts.recompute = func_ff && armed_ff && (steps == prepared_ff) && (elapsed_ff != '0);
   assign sts.div_last  = (cnt_ff == absg_pkg::DivLastCount);
   assign out_free      = !rsp_valid_ff || out_ready;
   assign sts.out_free  = out_free;

   assign rem_sh = {rem_ff, quo_ff[DvdW-1]};
   assign rem_ge = rem_sh >= {1'b0, divisor};

   // clamp to quarter / four times, then to 1..max; keep the prepared size if the change is small
   always_comb begin
      lo = prepared_ff[SizeW-1:2];
      if (lo == '0) lo = 17'd1;
      hi = {prepared_ff, 2'b00};
      if (hi > {2'd0, eff_max}) hi = {2'd0, eff_max};
      cand = quo_ff;
      if (cand < DvdW'(lo)) cand = DvdW'(lo);
      if (cand > DvdW'(hi)) cand = DvdW'(hi);
      if (cand == '0) cand = DvdW'(1);
      if (cand > DvdW'(eff_max)) cand = DvdW'(eff_max);
      cand_sz  = cand[SizeW-1:0];
      diff     = (cand_sz > prepared_ff) ? cand_sz - prepared_ff : prepared_ff - cand_sz;
      diff_x20 = 23'd20 * (23'(diff) + 23'd1);
      if ((diff == '0) || (diff_x20 <= 23'(prepared_ff))) begin
         clamp_size = prepared_ff;
      end else begin
         clamp_size = cand_sz;
      end
   end

   always_comb begin
      batch_in    = batch_ff;
      prepared_in = prepared_ff;
      armed_in    = armed_ff;
      active_in   = active_ff;
      run_in      = '0;
      restore_in  = 1'b0;
      steps_in    = '0;
      updated_in  = 1'b0;
      if (!func_ff) begin
         if (!scene_ff) begin
            armed_in = 1'b0;
            if (active_ff) begin
               active_in   = 1'b0;
               batch_in    = eff_init;
               prepared_in = '0;
               restore_in  = 1'b1;
            end
         end else begin
            active_in   = 1'b1;
            prepared_in = batch_ff;
            armed_in    = 1'b1;
            run_in      = batch_ff;
         end
      end else if (armed_ff) begin
         armed_in = 1'b0;
         steps_in = steps;
         if (sts.recompute) begin
            batch_in   = new_size_ff;
            updated_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= in_func;
         scene_ff   <= in_scene_active;
         tick_ff    <= in_completed_tick;
         elapsed_ff <= in_elapsed_us;
      end
      if (cmd.mul) begin
         num_ff <= NumW'(prepared_ff) * NumW'(cfg.target_batch_us);
      end
      if (cmd.div_start) begin
         quo_ff <= DvdW'({num_ff, 1'b0}) + DvdW'(e_clamped);
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? DvsW'(rem_sh - {1'b0, divisor}) : rem_sh[DvsW-1:0];
         quo_ff <= {quo_ff[DvdW-2:0], rem_ge};
         cnt_ff <= cnt_ff + CntW'(1);
      end
      if (cmd.clamp) begin
         new_size_ff <= clamp_size;
      end
      if (cmd.commit) begin
         run_ff     <= run_in;
         restore_ff <= restore_in;
         steps_ff   <= steps_in;
         updated_ff <= updated_in;
         next_ff    <= batch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff     <= absg_pkg::InitialReset;
         prepared_ff  <= '0;
         armed_ff     <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            batch_ff    <= batch_in;
            prepared_ff <= prepared_in;
            armed_ff    <= armed_in;
            active_ff   <= active_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid         = rsp_valid_ff;
   assign out_batch_to_run  = run_ff;
   assign out_restore_stock = restore_ff;
   assign out_steps_done    = steps_ff;
   assign out_batch_updated = updated_ff;
   assign out_next_batch    = next_ff;

endmodule
